// ===== hw/rtl/mtp_pkg.sv =====
// Shared constants for the momentum to pt/eta/phi/rapidity pipeline.
package mtp_pkg;

  localparam int ROOT_W     = 32;
  localparam int LOG_FRAC   = 20;
  localparam int NORM_STEPS = 6;
  localparam int LG_LAT     = NORM_STEPS + LOG_FRAC;
  localparam int LG_IN_W    = 33;
  localparam int LG_W       = 26;
  localparam int CXY_W      = 36;
  localparam int CZ_W       = 34;

  localparam logic signed [CZ_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [16:0]     PHI_LIMIT   = 17'sd25736;
  localparam logic [16:0]            LOG_SAT     = 17'd65536;
  localparam logic [31:0]            K_RAP       = 32'd1488522236;
  localparam logic [31:0]            K_ETA       = 32'd2977044472;

  // atan(2^-i) in units of 2^-30 rad
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd66987894,
    30'd33526107, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127,
    30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

endpackage

// ===== hw/rtl/mtp_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
module mtp_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] val_i,
  output logic [31:0] root_o
);

  localparam int N = mtp_pkg::ROOT_W;

  logic [33:0] rem_q  [N];
  logic [31:0] root_q [N];
  logic [63:0] val_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] val_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign val_in  = val_q[j-1];
    end

    assign rem_sh = {rem_in, val_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[j] <= {val_in[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[j]  <= 34'(rem_sh - trial);
          root_q[j] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh[33:0];
          root_q[j] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

// ===== hw/rtl/mtp_log2.sv =====
// Pipelined log2 in Q.20: shift normalize, then square-and-halve per bit.
module mtp_log2 (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [mtp_pkg::LG_IN_W-1:0] val_i,
  output logic [mtp_pkg::LG_W-1:0]    log_o
);

  localparam int NS = mtp_pkg::NORM_STEPS;
  localparam int NF = mtp_pkg::LOG_FRAC;
  localparam int VW = mtp_pkg::LG_IN_W;

  logic [VW-1:0] nw_q [NS];
  logic [5:0]    ns_q [NS];
  logic [31:0]   m_q  [NF];
  logic [NF-1:0] f_q  [NF];
  logic [5:0]    n_q  [NF];

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic [VW-1:0] w_in;
    logic [5:0]    s_in;

    if (k == 0) begin : g_first
      assign w_in = val_i;
      assign s_in = '0;
    end else begin : g_next
      assign w_in = nw_q[k-1];
      assign s_in = ns_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (w_in[VW-1 -: SH] == '0) begin
          nw_q[k] <= w_in << SH;
          ns_q[k] <= s_in + 6'(SH);
        end else begin
          nw_q[k] <= w_in;
          ns_q[k] <= s_in;
        end
      end
    end
  end

  for (genvar j = 0; j < NF; j++) begin : g_frac
    logic [31:0]   m_in;
    logic [NF-1:0] f_in;
    logic [5:0]    n_in;
    logic [63:0]   sq;
    logic          hi;

    if (j == 0) begin : g_first
      assign m_in = nw_q[NS-1][VW-1:1];
      assign f_in = '0;
      assign n_in = 6'd32 - ns_q[NS-1];
    end else begin : g_next
      assign m_in = m_q[j-1];
      assign f_in = f_q[j-1];
      assign n_in = n_q[j-1];
    end

    assign sq = {32'd0, m_in} * {32'd0, m_in};
    assign hi = sq[63];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j] <= hi ? sq[63:32] : sq[62:31];
        f_q[j] <= {f_in[NF-2:0], hi};
        n_q[j] <= n_in;
      end
    end
  end

  assign log_o = {n_q[NF-1], f_q[NF-1]};

endmodule

// ===== hw/rtl/momentum_to_pt_eta_phi_rapidity.sv =====
// Throughput: one request per cycle unless stalled; the 32-stage square roots, 26-stage
// log2 units and the CORDIC_STEPS-stage CORDIC are fully pipelined.
// A stall on the output freezes the whole pipeline; tready follows it directly.
// Reset (rst_ni low, asynchronous) clears all valid bits; data regs are not reset.
module momentum_to_pt_eta_phi_rapidity #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // mom_x, mom_y, mom_z, energy, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // trans_mom, azimuth, pseudo_rap, rapidity_out, pad
  output logic [2:0]   m_axis_tuser   // azimuth_ok, pseudo_rap_ok, rapidity_ok
);

  localparam int SQ_LAT  = mtp_pkg::ROOT_W;
  localparam int LG_LAT  = mtp_pkg::LG_LAT;
  localparam int G_IDX   = 4 + SQ_LAT + LG_LAT + 2;
  localparam int PHI_DLY = G_IDX - 2 - CORDIC_STEPS;
  localparam int XW      = mtp_pkg::CXY_W;
  localparam int ZW      = mtp_pkg::CZ_W;
  localparam int LW      = mtp_pkg::LG_W;
  localparam int IW      = mtp_pkg::LG_IN_W;

  typedef struct packed {
    logic [31:0] az;
    logic [30:0] e;
    logic        neg;
    logic        nz;
  } side_t;

  typedef struct packed {
    logic [31:0] pt;
    logic        eta_ok;
    logic        rap_ok;
    logic        neg;
    logic        nz;
  } lside_t;

  typedef struct packed {
    logic [15:0] phi;
    logic        ok;
  } phi_t;

  logic adv;
  logic out_vld_q;
  logic vld_q [G_IDX+1];

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= G_IDX; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k <= G_IDX; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[G_IDX];
    end
  end

  // stage A: capture
  logic signed [31:0] px_q, py_q, pz_q;
  logic [30:0]        e_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= s_axis_tdata[31:0];
      py_q <= s_axis_tdata[63:32];
      pz_q <= s_axis_tdata[95:64];
      e_q  <= s_axis_tdata[126:96];
    end
  end

  // stages B, C, D: magnitudes, squares, sums
  logic [31:0] ax_q, ay_q;
  logic [63:0] ax2_q, ay2_q, az2_q, pt2_q, p2_q;
  side_t       side_b_q, side_c_q, side_d_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q         <= px_q[31] ? (~px_q + 32'd1) : px_q;
      ay_q         <= py_q[31] ? (~py_q + 32'd1) : py_q;
      side_b_q.az  <= pz_q[31] ? (~pz_q + 32'd1) : pz_q;
      side_b_q.e   <= e_q;
      side_b_q.neg <= pz_q[31];
      side_b_q.nz  <= (pz_q != '0);

      ax2_q    <= {32'd0, ax_q} * {32'd0, ax_q};
      ay2_q    <= {32'd0, ay_q} * {32'd0, ay_q};
      az2_q    <= {32'd0, side_b_q.az} * {32'd0, side_b_q.az};
      side_c_q <= side_b_q;

      pt2_q    <= ax2_q + ay2_q;
      p2_q     <= ax2_q + ay2_q + az2_q;
      side_d_q <= side_c_q;
    end
  end

  logic [31:0] pt_root, p_root;

  mtp_isqrt u_sqrt_pt (.clk_i(clk_i), .en_i(adv), .val_i(pt2_q), .root_o(pt_root));
  mtp_isqrt u_sqrt_p  (.clk_i(clk_i), .en_i(adv), .val_i(p2_q),  .root_o(p_root));

  side_t sq_side_q [SQ_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_side_q[0] <= side_d_q;
      for (int k = 1; k < SQ_LAT; k++) sq_side_q[k] <= sq_side_q[k-1];
    end
  end

  // stage E: log operands and flags
  side_t       se;
  logic [IW-1:0] eta_num_q, eta_den_q, rap_num_q, rap_den_q;
  lside_t      le_q;

  assign se = sq_side_q[SQ_LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eta_num_q   <= {1'b0, p_root} + {1'b0, se.az};
      eta_den_q   <= {1'b0, pt_root};
      rap_num_q   <= {2'b00, se.e} + {1'b0, se.az};
      rap_den_q   <= {2'b00, se.e} - {1'b0, se.az};
      le_q.pt     <= pt_root;
      le_q.eta_ok <= (pt_root != '0);
      le_q.rap_ok <= ({1'b0, se.e} > se.az);
      le_q.neg    <= se.neg;
      le_q.nz     <= se.nz;
    end
  end

  logic [LW-1:0] lg_eta_num, lg_eta_den, lg_rap_num, lg_rap_den;

  mtp_log2 u_log_en (.clk_i(clk_i), .en_i(adv), .val_i(eta_num_q), .log_o(lg_eta_num));
  mtp_log2 u_log_ed (.clk_i(clk_i), .en_i(adv), .val_i(eta_den_q), .log_o(lg_eta_den));
  mtp_log2 u_log_rn (.clk_i(clk_i), .en_i(adv), .val_i(rap_num_q), .log_o(lg_rap_num));
  mtp_log2 u_log_rd (.clk_i(clk_i), .en_i(adv), .val_i(rap_den_q), .log_o(lg_rap_den));

  lside_t lg_side_q [LG_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lg_side_q[0] <= le_q;
      for (int k = 1; k < LG_LAT; k++) lg_side_q[k] <= lg_side_q[k-1];
    end
  end

  // stages F, G: log difference, scale by ln2 (by ln2/2 for rapidity)
  logic [LW-1:0] de_q, dr_q;
  logic [57:0]   pe_q, pr_q;
  lside_t        lf_q, lgs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      de_q  <= (lg_eta_num > lg_eta_den) ? (lg_eta_num - lg_eta_den) : '0;
      dr_q  <= (lg_rap_num > lg_rap_den) ? (lg_rap_num - lg_rap_den) : '0;
      lf_q  <= lg_side_q[LG_LAT-1];
      pe_q  <= {32'd0, de_q} * {26'd0, mtp_pkg::K_ETA};
      pr_q  <= {32'd0, dr_q} * {26'd0, mtp_pkg::K_RAP};
      lgs_q <= lf_q;
    end
  end

  // CORDIC: quadrant pre-rotation, then one micro-rotation per stage
  logic signed [XW-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz_q [CORDIC_STEPS+1];
  logic                 cok_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cok_q[0] <= (px_q != '0) || (py_q != '0);
      if (px_q[31] && !py_q[31]) begin
        cx_q[0] <= XW'(py_q);
        cy_q[0] <= -XW'(px_q);
        cz_q[0] <= mtp_pkg::ANG_HALF_PI;
      end else if (px_q[31]) begin
        cx_q[0] <= -XW'(py_q);
        cy_q[0] <= XW'(px_q);
        cz_q[0] <= -mtp_pkg::ANG_HALF_PI;
      end else begin
        cx_q[0] <= XW'(px_q);
        cy_q[0] <= XW'(py_q);
        cz_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;

    assign xs  = cx_q[i] >>> i;
    assign ys  = cy_q[i] >>> i;
    assign ang = ZW'(mtp_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cok_q[i+1] <= cok_q[i];
        if (cy_q[i][XW-1]) begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - ang;
        end else begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + ang;
        end
      end
    end
  end

  // round to Q3.13, clamp, then delay to line up with stage G
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   phi17;
  phi_t                 pd_q [PHI_DLY+1];

  assign z_rnd = cz_q[CORDIC_STEPS] + ZW'(65536);
  assign phi17 = z_rnd[ZW-1:17];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0].ok <= cok_q[CORDIC_STEPS];
      if (!cok_q[CORDIC_STEPS]) begin
        pd_q[0].phi <= '0;
      end else if (phi17 > mtp_pkg::PHI_LIMIT) begin
        pd_q[0].phi <= mtp_pkg::PHI_LIMIT[15:0];
      end else if (phi17 < -mtp_pkg::PHI_LIMIT) begin
        pd_q[0].phi <= 16'(-mtp_pkg::PHI_LIMIT);
      end else begin
        pd_q[0].phi <= phi17[15:0];
      end
      for (int k = 1; k <= PHI_DLY; k++) pd_q[k] <= pd_q[k-1];
    end
  end

  // stage H: output register
  logic [58:0] sum_e, sum_r;
  logic [16:0] mag_e, mag_r;
  logic [17:0] eta_d, rap_d;
  logic [31:0] pt_out_q;
  logic [15:0] phi_out_q;
  logic [17:0] eta_out_q, rap_out_q;
  logic        phi_ok_q, eta_ok_q, rap_ok_q;

  always_comb begin
    sum_e = {1'b0, pe_q} + (59'd1 << 39);
    sum_r = {1'b0, pr_q} + (59'd1 << 39);
    if (!lgs_q.eta_ok || (sum_e[58:40] > 19'(mtp_pkg::LOG_SAT))) begin
      mag_e = mtp_pkg::LOG_SAT;
    end else begin
      mag_e = sum_e[56:40];
    end
    if (!lgs_q.rap_ok || (sum_r[58:40] > 19'(mtp_pkg::LOG_SAT))) begin
      mag_r = mtp_pkg::LOG_SAT;
    end else begin
      mag_r = sum_r[56:40];
    end
    if (!lgs_q.nz) begin
      eta_d = '0;
      rap_d = '0;
    end else if (lgs_q.neg) begin
      eta_d = -{1'b0, mag_e};
      rap_d = -{1'b0, mag_r};
    end else begin
      eta_d = {1'b0, mag_e};
      rap_d = {1'b0, mag_r};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_out_q  <= lgs_q.pt;
      phi_out_q <= pd_q[PHI_DLY].phi;
      phi_ok_q  <= pd_q[PHI_DLY].ok;
      eta_out_q <= eta_d;
      rap_out_q <= rap_d;
      eta_ok_q  <= lgs_q.eta_ok;
      rap_ok_q  <= lgs_q.rap_ok;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, rap_out_q, eta_out_q, phi_out_q, pt_out_q};
  assign m_axis_tuser  = {rap_ok_q, eta_ok_q, phi_ok_q};

  a_in_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output register empty");

  a_phi_zero_undefined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[47:32] == 16'd0))
    else $error("azimuth nonzero while undefined");

  a_phi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[47:32]) <= 16'sd25736 &&
                       $signed(m_axis_tdata[47:32]) >= -16'sd25736))
    else $error("azimuth outside clamp range");

  a_eta_sat_undefined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1]) |->
      (m_axis_tdata[65:48] == 18'd65536 || m_axis_tdata[65:48] == 18'h30000 ||
       m_axis_tdata[65:48] == 18'd0))
    else $error("pseudorapidity not saturated while undefined");

endmodule
